/* design/pose_jump_and_staleness_monitor_defines.svh */
// Assertion macros shared by the pose monitor RTL.
// No dependencies; the checks compile away when SYNTHESIS is defined.
`ifndef POSE_JUMP_AND_STALENESS_MONITOR_DEFINES_SVH
`define POSE_JUMP_AND_STALENESS_MONITOR_DEFINES_SVH

`ifndef SYNTHESIS
`define PJSM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PJSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PJSM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define PJSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

/* design/pjsm_pkg.sv */
// Types and constants of the pose jump and staleness monitor.
// Used by pose_jump_and_staleness_monitor and tb_top; depends on nothing.
`default_nettype none

package pjsm_pkg;

    // Width of the shift-add accumulator and of the multiplier operand.
    localparam int ACC_W = 97;
    localparam int MPL_W = 48;
    localparam int D2_W  = 50;

    localparam logic [15:0] SPEED_MIN_MMPS = 16'd10;
    localparam logic [47:0] GAP_MIN_US     = 48'd1;
    // speed * gap at or above this puts 1.3 times the travel beyond any distance.
    localparam logic [63:0] TRAVEL_CLAMP   = 64'd20000000000000;
    // (1e7)^2: scales the squared distance against (13 * speed * gap)^2.
    localparam logic [47:0] SCALE_SQ       = 48'd100000000000000;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    localparam logic [1:0] REASON_NONE   = 2'd0;
    localparam logic [1:0] REASON_NOPOSE = 2'd1;
    localparam logic [1:0] REASON_JUMP   = 2'd2;
    localparam logic [1:0] REASON_STALE  = 2'd3;

    localparam logic [1:0] REG_WD_EN   = 2'd0;
    localparam logic [1:0] REG_THR     = 2'd1;
    localparam logic [1:0] REG_TIMEOUT = 2'd2;

    localparam logic        WD_EN_RST   = 1'b1;
    localparam logic [15:0] THR_RST     = 16'd500;
    localparam logic [31:0] TIMEOUT_RST = 32'd500000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_DX,
        S_DY,
        S_THR,
        S_ST,
        S_CLAMP,
        S_PP,
        S_LOADS,
        S_D2S,
        S_CMP,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

/* design/pose_jump_and_staleness_monitor.sv */
// Pose jump and staleness monitor: flags position jumps and reports pose health.
// Depends on pjsm_pkg and pose_jump_and_staleness_monitor_defines.svh.
//
// One beat is taken at a time. A query or a sample that needs no jump check
// passes S_SETUP and S_DONE before its result reaches the output register, and
// the next beat is taken back in S_IDLE. A sample that is checked runs a shift-add
// multiplier, one multiplier bit per cycle, for dx^2 + dy^2, then speed * gap,
// (13 * speed * gap)^2 and the scaled squared distance; it stops early when the
// squared distance is within the threshold or the travel reaches the clamp, and a
// multiply ends after the top set bit of its multiplier. The output register lets
// the next beat be accepted while a result waits on m_tready.
`default_nettype none

`include "pose_jump_and_staleness_monitor_defines.svh"

module pose_jump_and_staleness_monitor
(
    input  wire logic          clk,
    input  wire logic          rst_n,

    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,

    input  wire logic          s_tvalid,
    output logic               s_tready,
    // pos_x[23:0], pos_y[47:24], time_us[95:48], max_speed[111:96]
    input  wire logic [111:0]  s_tdata,
    // action[0]
    input  wire logic          s_tuser,

    output logic               m_tvalid,
    input  wire logic          m_tready,
    // healthy[0], fail_reason[2:1], pose_fresh[3], last_x[27:4], last_y[51:28],
    // jump_now[52], zero[55:53]
    output logic [55:0]        m_tdata
);

    localparam int ACC_W = pjsm_pkg::ACC_W;
    localparam int MPL_W = pjsm_pkg::MPL_W;
    localparam int D2_W  = pjsm_pkg::D2_W;

    pjsm_pkg::state_t state_reg, state_next;

    logic        wd_en_reg;
    logic [15:0] thr_reg;
    logic [31:0] timeout_reg;
    logic [31:0] thr_sq_reg;

    logic               in_action_reg, in_action_next;
    logic signed [23:0] in_x_reg, in_x_next;
    logic signed [23:0] in_y_reg, in_y_next;
    logic [47:0]        in_time_reg, in_time_next;
    logic [15:0]        in_speed_reg, in_speed_next;

    logic signed [23:0] prev_x_reg, prev_x_next;
    logic signed [23:0] prev_y_reg, prev_y_next;
    logic [47:0]        prev_time_reg, prev_time_next;
    logic               prev_valid_reg, prev_valid_next;
    logic               jump_latched_reg, jump_latched_next;
    logic               pose_seen_reg, pose_seen_next;
    logic signed [23:0] stored_x_reg, stored_x_next;
    logic signed [23:0] stored_y_reg, stored_y_next;
    logic [47:0]        stored_time_reg, stored_time_next;

    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [ACC_W-1:0]   mcand_reg, mcand_next;
    logic [MPL_W-1:0]   mplier_reg, mplier_next;
    logic [D2_W-1:0]    d2_reg, d2_next;
    logic [ACC_W-2:0]   cmp_reg, cmp_next;
    logic [24:0]        mag_y_reg, mag_y_next;
    logic [47:0]        gap_reg, gap_next;

    logic        res_healthy_reg, res_healthy_next;
    logic [1:0]  res_reason_reg, res_reason_next;
    logic        res_fresh_reg, res_fresh_next;
    logic        res_jump_reg, res_jump_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_healthy_reg, out_healthy_next;
    logic [1:0]         out_reason_reg, out_reason_next;
    logic               out_fresh_reg, out_fresh_next;
    logic signed [23:0] out_x_reg, out_x_next;
    logic signed [23:0] out_y_reg, out_y_next;
    logic               out_jump_reg, out_jump_next;

    logic             cfg_wr;
    logic             in_beat;
    logic             out_free;
    logic [ACC_W-1:0] unit_add;
    logic             unit_last;
    logic             moving;
    logic [24:0]      dx, dy, mag_x, mag_y;
    logic [48:0]      gap_diff, age_diff;
    logic             gap_ok, age_over, check_jump;
    logic [47:0]      st_lo, p_val;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wd_en_reg   <= pjsm_pkg::WD_EN_RST;
            thr_reg     <= pjsm_pkg::THR_RST;
            timeout_reg <= pjsm_pkg::TIMEOUT_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                pjsm_pkg::REG_WD_EN:   wd_en_reg   <= pwdata[0];
                pjsm_pkg::REG_THR:     thr_reg     <= pwdata[15:0];
                pjsm_pkg::REG_TIMEOUT: timeout_reg <= pwdata;
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            pjsm_pkg::REG_WD_EN:   prdata = {31'd0, wd_en_reg};
            pjsm_pkg::REG_THR:     prdata = {16'd0, thr_reg};
            pjsm_pkg::REG_TIMEOUT: prdata = timeout_reg;
            default:               prdata = 32'd0;
        endcase
    end

    // The user changes the threshold only while idle; the block does not enforce it.
    always_ff @(posedge clk)
    begin
        thr_sq_reg <= {16'd0, thr_reg} * {16'd0, thr_reg};
    end

    // ------------------------------------------------------------------
    // Shared shift-add multiplier step and sample arithmetic
    // ------------------------------------------------------------------
    assign unit_add  = acc_reg + (mplier_reg[0] ? mcand_reg : {ACC_W{1'b0}});
    assign unit_last = (mplier_reg[MPL_W-1:1] == '0);

    assign moving = in_speed_reg > pjsm_pkg::SPEED_MIN_MMPS;
    assign dx     = {in_x_reg[23], in_x_reg} - {prev_x_reg[23], prev_x_reg};
    assign dy     = {in_y_reg[23], in_y_reg} - {prev_y_reg[23], prev_y_reg};
    assign mag_x  = dx[24] ? (25'd0 - dx) : dx;
    assign mag_y  = dy[24] ? (25'd0 - dy) : dy;

    // A borrow means the new stamp is earlier; such a gap or age counts as negative.
    assign gap_diff = {1'b0, in_time_reg} - {1'b0, prev_time_reg};
    assign gap_ok   = !gap_diff[48] && (gap_diff[47:0] > pjsm_pkg::GAP_MIN_US);
    assign age_diff = {1'b0, in_time_reg} - {1'b0, stored_time_reg};
    assign age_over = !age_diff[48] && (age_diff[47:0] > {16'd0, timeout_reg});

    assign check_jump = wd_en_reg && moving && prev_valid_reg && gap_ok;

    assign st_lo = acc_reg[47:0];
    assign p_val = (st_lo << 3) + (st_lo << 2) + st_lo;

    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == pjsm_pkg::S_IDLE);

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pjsm_pkg::S_IDLE:
                if (in_beat)
                    state_next = pjsm_pkg::S_SETUP;
            pjsm_pkg::S_SETUP:
                if (in_action_reg == pjsm_pkg::ACT_SAMPLE && check_jump)
                    state_next = pjsm_pkg::S_DX;
                else
                    state_next = pjsm_pkg::S_DONE;
            pjsm_pkg::S_DX:
                if (unit_last)
                    state_next = pjsm_pkg::S_DY;
            pjsm_pkg::S_DY:
                if (unit_last)
                    state_next = pjsm_pkg::S_THR;
            pjsm_pkg::S_THR:
                if (acc_reg > {{(ACC_W-32){1'b0}}, thr_sq_reg})
                    state_next = pjsm_pkg::S_ST;
                else
                    state_next = pjsm_pkg::S_DONE;
            pjsm_pkg::S_ST:
                if (unit_last)
                    state_next = pjsm_pkg::S_CLAMP;
            pjsm_pkg::S_CLAMP:
                if (acc_reg >= {{(ACC_W-64){1'b0}}, pjsm_pkg::TRAVEL_CLAMP})
                    state_next = pjsm_pkg::S_DONE;
                else
                    state_next = pjsm_pkg::S_PP;
            pjsm_pkg::S_PP:
                if (unit_last)
                    state_next = pjsm_pkg::S_LOADS;
            pjsm_pkg::S_LOADS:
                state_next = pjsm_pkg::S_D2S;
            pjsm_pkg::S_D2S:
                if (unit_last)
                    state_next = pjsm_pkg::S_CMP;
            pjsm_pkg::S_CMP:
                state_next = pjsm_pkg::S_DONE;
            pjsm_pkg::S_DONE:
                if (out_free)
                    state_next = pjsm_pkg::S_IDLE;
            default:
                state_next = pjsm_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: datapath and state updates
    // ------------------------------------------------------------------
    always_comb
    begin
        in_action_next    = in_action_reg;
        in_x_next         = in_x_reg;
        in_y_next         = in_y_reg;
        in_time_next      = in_time_reg;
        in_speed_next     = in_speed_reg;
        prev_x_next       = prev_x_reg;
        prev_y_next       = prev_y_reg;
        prev_time_next    = prev_time_reg;
        prev_valid_next   = prev_valid_reg;
        jump_latched_next = jump_latched_reg;
        pose_seen_next    = pose_seen_reg;
        stored_x_next     = stored_x_reg;
        stored_y_next     = stored_y_reg;
        stored_time_next  = stored_time_reg;
        acc_next          = acc_reg;
        mcand_next        = mcand_reg;
        mplier_next       = mplier_reg;
        d2_next           = d2_reg;
        cmp_next          = cmp_reg;
        mag_y_next        = mag_y_reg;
        gap_next          = gap_reg;
        res_healthy_next  = res_healthy_reg;
        res_reason_next   = res_reason_reg;
        res_fresh_next    = res_fresh_reg;
        res_jump_next     = res_jump_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        out_healthy_next  = out_healthy_reg;
        out_reason_next   = out_reason_reg;
        out_fresh_next    = out_fresh_reg;
        out_x_next        = out_x_reg;
        out_y_next        = out_y_reg;
        out_jump_next     = out_jump_reg;

        case (state_reg)
            pjsm_pkg::S_IDLE:
                if (in_beat)
                begin
                    in_action_next = s_tuser;
                    in_x_next      = s_tdata[23:0];
                    in_y_next      = s_tdata[47:24];
                    in_time_next   = s_tdata[95:48];
                    in_speed_next  = s_tdata[111:96];
                end
            pjsm_pkg::S_SETUP:
            begin
                res_healthy_next = 1'b1;
                res_reason_next  = pjsm_pkg::REASON_NONE;
                res_fresh_next   = 1'b1;
                res_jump_next    = 1'b0;
                if (in_action_reg == pjsm_pkg::ACT_QUERY)
                begin
                    res_fresh_next = pose_seen_reg && (timeout_reg == 32'd0 || !age_over);
                    if (!wd_en_reg)
                    begin
                        res_healthy_next = 1'b1;
                    end
                    else if (!moving)
                    begin
                        // Standstill drops the pending jump and the jump reference.
                        jump_latched_next = 1'b0;
                        prev_valid_next   = 1'b0;
                    end
                    else if (!pose_seen_reg)
                    begin
                        res_healthy_next = 1'b0;
                        res_reason_next  = pjsm_pkg::REASON_NOPOSE;
                    end
                    else if (jump_latched_reg)
                    begin
                        jump_latched_next = 1'b0;
                        res_healthy_next  = 1'b0;
                        res_reason_next   = pjsm_pkg::REASON_JUMP;
                    end
                    else if (age_over)
                    begin
                        res_healthy_next = 1'b0;
                        res_reason_next  = pjsm_pkg::REASON_STALE;
                    end
                end
                else
                begin
                    // The differences to the old reference are captured before it moves on.
                    mag_y_next  = mag_y;
                    gap_next    = gap_diff[47:0];
                    acc_next    = '0;
                    mcand_next  = {{(ACC_W-25){1'b0}}, mag_x};
                    mplier_next = {{(MPL_W-25){1'b0}}, mag_x};
                    if (wd_en_reg && moving)
                    begin
                        prev_x_next     = in_x_reg;
                        prev_y_next     = in_y_reg;
                        prev_time_next  = in_time_reg;
                        prev_valid_next = 1'b1;
                    end
                    stored_x_next    = in_x_reg;
                    stored_y_next    = in_y_reg;
                    stored_time_next = in_time_reg;
                    pose_seen_next   = 1'b1;
                end
            end
            pjsm_pkg::S_DX:
            begin
                acc_next    = unit_add;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                if (unit_last)
                begin
                    // dy^2 accumulates on top of dx^2.
                    mcand_next  = {{(ACC_W-25){1'b0}}, mag_y_reg};
                    mplier_next = {{(MPL_W-25){1'b0}}, mag_y_reg};
                end
            end
            pjsm_pkg::S_DY, pjsm_pkg::S_ST, pjsm_pkg::S_PP, pjsm_pkg::S_D2S:
            begin
                acc_next    = unit_add;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
            end
            pjsm_pkg::S_THR:
            begin
                d2_next     = acc_reg[D2_W-1:0];
                acc_next    = '0;
                mcand_next  = {{(ACC_W-48){1'b0}}, gap_reg};
                mplier_next = {{(MPL_W-16){1'b0}}, in_speed_reg};
            end
            pjsm_pkg::S_CLAMP:
            begin
                acc_next    = '0;
                mcand_next  = {{(ACC_W-48){1'b0}}, p_val};
                mplier_next = p_val;
            end
            pjsm_pkg::S_LOADS:
            begin
                cmp_next    = acc_reg[ACC_W-2:0];
                acc_next    = '0;
                mcand_next  = {{(ACC_W-D2_W){1'b0}}, d2_reg};
                mplier_next = pjsm_pkg::SCALE_SQ;
            end
            pjsm_pkg::S_CMP:
                if (acc_reg > {1'b0, cmp_reg})
                begin
                    res_jump_next     = 1'b1;
                    jump_latched_next = 1'b1;
                end
            pjsm_pkg::S_DONE:
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_healthy_next = res_healthy_reg;
                    out_reason_next  = res_reason_reg;
                    out_fresh_next   = res_fresh_reg;
                    out_x_next       = stored_x_reg;
                    out_y_next       = stored_y_reg;
                    out_jump_next    = res_jump_reg;
                end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= pjsm_pkg::S_IDLE;
            prev_x_reg       <= '0;
            prev_y_reg       <= '0;
            prev_time_reg    <= '0;
            prev_valid_reg   <= 1'b0;
            jump_latched_reg <= 1'b0;
            pose_seen_reg    <= 1'b0;
            stored_x_reg     <= '0;
            stored_y_reg     <= '0;
            stored_time_reg  <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            prev_x_reg       <= prev_x_next;
            prev_y_reg       <= prev_y_next;
            prev_time_reg    <= prev_time_next;
            prev_valid_reg   <= prev_valid_next;
            jump_latched_reg <= jump_latched_next;
            pose_seen_reg    <= pose_seen_next;
            stored_x_reg     <= stored_x_next;
            stored_y_reg     <= stored_y_next;
            stored_time_reg  <= stored_time_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_action_reg   <= in_action_next;
        in_x_reg        <= in_x_next;
        in_y_reg        <= in_y_next;
        in_time_reg     <= in_time_next;
        in_speed_reg    <= in_speed_next;
        acc_reg         <= acc_next;
        mcand_reg       <= mcand_next;
        mplier_reg      <= mplier_next;
        d2_reg          <= d2_next;
        cmp_reg         <= cmp_next;
        mag_y_reg       <= mag_y_next;
        gap_reg         <= gap_next;
        res_healthy_reg <= res_healthy_next;
        res_reason_reg  <= res_reason_next;
        res_fresh_reg   <= res_fresh_next;
        res_jump_reg    <= res_jump_next;
        out_healthy_reg <= out_healthy_next;
        out_reason_reg  <= out_reason_next;
        out_fresh_reg   <= out_fresh_next;
        out_x_reg       <= out_x_next;
        out_y_reg       <= out_y_next;
        out_jump_reg    <= out_jump_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_jump_reg, out_y_reg, out_x_reg, out_fresh_reg,
                       out_reason_reg, out_healthy_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PJSM_ASSERT_IMP(a_jump_beat_healthy, clk, rst_n,
        m_tvalid && out_jump_reg,
        out_healthy_reg && out_reason_reg == pjsm_pkg::REASON_NONE,
        "jump beat carries a health failure")
    `PJSM_ASSERT_NEXT(a_jump_latches, clk, rst_n,
        (state_reg == pjsm_pkg::S_CMP && acc_reg > {1'b0, cmp_reg}),
        jump_latched_reg && res_jump_reg,
        "detected jump was not latched")
    `PJSM_ASSERT_NEXT(a_jump_report_clears, clk, rst_n,
        state_reg == pjsm_pkg::S_SETUP && in_action_reg == pjsm_pkg::ACT_QUERY &&
        res_reason_next == pjsm_pkg::REASON_JUMP,
        !jump_latched_reg,
        "reported jump left the latch set")
    `PJSM_ASSERT_NEXT(a_dx_holds, clk, rst_n,
        state_reg == pjsm_pkg::S_DX && !unit_last,
        state_reg == pjsm_pkg::S_DX,
        "multiply left before its last multiplier bit")

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for pose_jump_and_staleness_monitor: drives pose samples and
// health queries with random idling on both streams, predicts each verdict in SystemVerilog.
// Depends on pjsm_pkg and the monitor RTL only.

module tb_top;

    localparam int          LIMIT_CYCLES = 1000000;
    localparam logic [15:0] SPEED_FLOOR  = 16'd10;
    localparam logic [47:0] GAP_FLOOR    = 48'd1;
    localparam logic [63:0] TRAVEL_CAP   = 64'd20000000000000;
    localparam logic [127:0] DIST_SCALE  = 128'd100000000000000;

    typedef struct {
        logic                act;
        logic signed [23:0]  x;
        logic signed [23:0]  y;
        logic [47:0]         t;
        logic [15:0]         speed;
    } pose_beat_t;

    typedef struct {
        logic                healthy;
        logic [1:0]          reason;
        logic                fresh;
        logic signed [23:0]  lx;
        logic signed [23:0]  ly;
        logic                jump;
    } verdict_t;

    logic          clk;
    logic          rst_n;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [3:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;
    logic          s_tvalid;
    logic          s_tready;
    // pos_x[23:0], pos_y[47:24], time_us[95:48], max_speed[111:96]
    logic [111:0]  s_tdata;
    // action[0]
    logic          s_tuser;
    logic          m_tvalid;
    logic          m_tready;
    // healthy[0], fail_reason[2:1], pose_fresh[3], last_x[27:4], last_y[51:28], jump_now[52]
    logic [55:0]   m_tdata;

    pose_jump_and_staleness_monitor u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Predictor copy of the configuration and of the monitor state.
    logic               cfg_wd;
    logic [15:0]        cfg_thr;
    logic [31:0]        cfg_timeout;
    logic signed [23:0] anchor_x;
    logic signed [23:0] anchor_y;
    logic [47:0]        anchor_t;
    logic               anchor_ok;
    logic               jump_pending;
    logic               have_pose;
    logic signed [23:0] last_x;
    logic signed [23:0] last_y;
    logic [47:0]        last_t;

    pose_beat_t pose_beat_q[$];
    verdict_t   verdict_q[$];
    pose_beat_t drv_beat;
    logic       beat_taken;

    int n_queued;
    int n_accepted;
    int n_checked;
    int n_samples;
    int n_jumps;
    int n_queries;
    int reason_cnt[4];
    int err_count;
    int cycles;
    int src_idle;
    int snk_idle;
    logic src_calm;
    logic snk_calm;

    // Generator cursor: the track that well-formed sequences follow.
    logic signed [23:0] cur_x;
    logic signed [23:0] cur_y;
    logic [47:0]        cur_t;

    always #5 clk = ~clk;

    function automatic logic sample_jumped(logic signed [23:0] x, logic signed [23:0] y,
                                           logic [15:0] speed, logic [47:0] gap);
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic [63:0]        d2;
        logic [63:0]        thr;
        logic [63:0]        st;
        logic [63:0]        p;
        logic [127:0]       lhs;
        logic [127:0]       rhs;
        dx  = x;
        dy  = y;
        dx  = dx - anchor_x;
        dy  = dy - anchor_y;
        d2  = dx * dx + dy * dy;
        thr = cfg_thr;
        if (d2 <= thr * thr)
            return 1'b0;
        st = {48'd0, speed};
        st = st * {16'd0, gap};
        if (st >= TRAVEL_CAP)
            return 1'b0;
        p   = 64'd13 * st;
        lhs = d2;
        lhs = lhs * DIST_SCALE;
        rhs = p;
        rhs = rhs * rhs;
        return lhs > rhs;
    endfunction

    // Works out the verdict for one accepted beat and advances the predicted state.
    function automatic verdict_t predict_pose_health(pose_beat_t b);
        verdict_t    v;
        logic        moving;
        logic [47:0] age;
        v.healthy = 1'b1;
        v.reason  = pjsm_pkg::REASON_NONE;
        v.fresh   = 1'b1;
        v.jump    = 1'b0;
        moving    = b.speed > SPEED_FLOOR;
        if (b.act == pjsm_pkg::ACT_SAMPLE)
        begin
            if (cfg_wd && moving)
            begin
                if (anchor_ok && b.t > anchor_t && b.t - anchor_t > GAP_FLOOR)
                begin
                    if (sample_jumped(b.x, b.y, b.speed, b.t - anchor_t))
                    begin
                        jump_pending = 1'b1;
                        v.jump       = 1'b1;
                    end
                end
                anchor_x  = b.x;
                anchor_y  = b.y;
                anchor_t  = b.t;
                anchor_ok = 1'b1;
            end
            last_x    = b.x;
            last_y    = b.y;
            last_t    = b.t;
            have_pose = 1'b1;
        end
        else
        begin
            age = (b.t > last_t) ? b.t - last_t : 48'd0;
            if (cfg_wd)
            begin
                if (!moving)
                begin
                    jump_pending = 1'b0;
                    anchor_ok    = 1'b0;
                end
                else if (!have_pose)
                begin
                    v.healthy = 1'b0;
                    v.reason  = pjsm_pkg::REASON_NOPOSE;
                end
                else if (jump_pending)
                begin
                    jump_pending = 1'b0;
                    v.healthy    = 1'b0;
                    v.reason     = pjsm_pkg::REASON_JUMP;
                end
                else if (age > {16'd0, cfg_timeout})
                begin
                    v.healthy = 1'b0;
                    v.reason  = pjsm_pkg::REASON_STALE;
                end
            end
            v.fresh = have_pose && (cfg_timeout == 32'd0 || age <= {16'd0, cfg_timeout});
        end
        v.lx = last_x;
        v.ly = last_y;
        return v;
    endfunction

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] seen);
        if (want !== seen)
        begin
            err_count++;
            if (err_count <= 50)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
        end
    endtask

    // Source side: one beat at a time from the pending queue, with random gaps.
    always @(negedge clk)
    begin : drive_src
        pose_beat_t b;
        if (rst_n)
        begin
            if ($urandom_range(0, 63) == 0)
                src_calm <= !src_calm;
            if (!s_tvalid || beat_taken)
            begin
                if (src_idle > 0)
                begin
                    src_idle <= src_idle - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pose_beat_q.size() > 0)
                begin
                    b        = pose_beat_q.pop_front();
                    drv_beat = b;
                    s_tdata  <= {b.speed, b.t, b.y, b.x};
                    s_tuser  <= b.act;
                    s_tvalid <= 1'b1;
                    src_idle <= src_calm ? 0 : pick_idle();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sink side: random back-pressure, with calm stretches of none.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ($urandom_range(0, 63) == 0)
                snk_calm <= !snk_calm;
            if (snk_idle > 0)
            begin
                m_tready <= 1'b0;
                snk_idle <= snk_idle - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!snk_calm && $urandom_range(0, 3) == 0)
                    snk_idle <= pick_idle();
            end
        end
    end

    always @(posedge clk)
    begin : watch
        verdict_t want;
        verdict_t got;
        if (rst_n)
        begin
            cycles++;
            if (cycles > LIMIT_CYCLES)
            begin
                $display("Timeout after %0d cycles", cycles);
                $display("Some tests failed");
                $finish;
            end
            else
            begin
                // Results are checked before the new beat is predicted, so a result
                // never meets the expectation of a beat taken at the same edge.
                if (m_tvalid && m_tready)
                begin
                    got.healthy = m_tdata[0];
                    got.reason  = m_tdata[2:1];
                    got.fresh   = m_tdata[3];
                    got.lx      = m_tdata[27:4];
                    got.ly      = m_tdata[51:28];
                    got.jump    = m_tdata[52];
                    if (verdict_q.size() == 0)
                    begin
                        err_count++;
                        if (err_count <= 50)
                            $display("%0t: unexpected result beat, actual %0h", $time, m_tdata);
                    end
                    else
                    begin
                        want = verdict_q.pop_front();
                        n_checked++;
                        check_field("healthy", want.healthy, got.healthy);
                        check_field("fail_reason", want.reason, got.reason);
                        check_field("pose_fresh", want.fresh, got.fresh);
                        check_field("last_x", want.lx, got.lx);
                        check_field("last_y", want.ly, got.ly);
                        check_field("jump_now", want.jump, got.jump);
                    end
                end
                beat_taken = s_tvalid && s_tready;
                if (beat_taken)
                begin
                    want = predict_pose_health(drv_beat);
                    verdict_q.push_back(want);
                    n_accepted++;
                    if (drv_beat.act == pjsm_pkg::ACT_SAMPLE)
                    begin
                        n_samples++;
                        if (want.jump)
                            n_jumps++;
                    end
                    else
                    begin
                        n_queries++;
                        reason_cnt[want.reason]++;
                    end
                end
            end
        end
    end

    task automatic add_sample(logic signed [23:0] x, logic signed [23:0] y, logic [47:0] t,
                              logic [15:0] spd);
        pose_beat_t b;
        b.act   = pjsm_pkg::ACT_SAMPLE;
        b.x     = x;
        b.y     = y;
        b.t     = t;
        b.speed = spd;
        pose_beat_q.push_back(b);
        n_queued++;
    endtask

    task automatic add_query(logic [47:0] t, logic [15:0] spd, logic signed [23:0] x = 0,
                             logic signed [23:0] y = 0);
        pose_beat_t b;
        b.act   = pjsm_pkg::ACT_QUERY;
        b.x     = x;
        b.y     = y;
        b.t     = t;
        b.speed = spd;
        pose_beat_q.push_back(b);
        n_queued++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            pjsm_pkg::REG_WD_EN:   cfg_wd      = val[0];
            pjsm_pkg::REG_THR:     cfg_thr     = val[15:0];
            pjsm_pkg::REG_TIMEOUT: cfg_timeout = val;
            default:               ;
        endcase
    endtask

    task automatic apply_settings(logic wd, logic [15:0] thr, logic [31:0] timeout);
        write_reg(pjsm_pkg::REG_WD_EN, {31'd0, wd});
        write_reg(pjsm_pkg::REG_THR, {16'd0, thr});
        write_reg(pjsm_pkg::REG_TIMEOUT, timeout);
    endtask

    task automatic wait_drain();
        while (n_accepted < n_queued || verdict_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mostly plausible tracks (samples near the last one, queries at ages around the
    // timeout), with a tenth of the beats fully random.
    task automatic run_random(int n);
        logic [63:0]        w;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic [47:0]        t;
        logic [15:0]        spd;
        logic [47:0]        age;
        int                 r;
        int                 dx;
        int                 dy;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                w   = {$urandom, $urandom};
                x   = w[23:0];
                y   = w[47:24];
                spd = w[63:48];
                w   = {$urandom, $urandom};
                t   = w[47:0];
                if ($urandom_range(0, 1))
                    add_sample(x, y, t, spd);
                else
                    add_query(t, spd, x, y);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    spd = 16'($urandom_range(11, 3000));
                else if (r < 85)
                    spd = 16'($urandom_range(0, 10));
                else if (r < 95)
                    spd = 16'($urandom_range(3001, 65535));
                else
                    spd = 16'hFFFF;
                if ($urandom_range(0, 99) < 65)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 80)
                        cur_t = cur_t + 48'($urandom_range(2, 200000));
                    else if (r < 90)
                        cur_t = cur_t + 48'($urandom_range(0, 1));
                    else if (r < 95)
                        cur_t = cur_t - 48'($urandom_range(1, 100000));
                    else
                        cur_t = cur_t + 48'($urandom_range(400000, 2000000));
                    r = $urandom_range(0, 99);
                    if (r < 80)
                    begin
                        dx = $urandom_range(0, 1500);
                        dy = $urandom_range(0, 1500);
                    end
                    else
                    begin
                        dx = $urandom_range(0, 100000);
                        dy = $urandom_range(0, 100000);
                    end
                    if ($urandom_range(0, 1))
                        dx = -dx;
                    if ($urandom_range(0, 1))
                        dy = -dy;
                    cur_x = cur_x + dx[23:0];
                    cur_y = cur_y + dy[23:0];
                    add_sample(cur_x, cur_y, cur_t, spd);
                end
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 40)
                        age = 48'($urandom_range(0, 1000));
                    else if (r < 70)
                    begin
                        // Ages one below, at and one above the timeout.
                        age = {16'd0, cfg_timeout} + 48'($urandom_range(0, 2));
                        if (age > 0)
                            age = age - 1;
                    end
                    else
                        age = 48'($urandom_range(0, 2 * 1000000));
                    add_query(cur_t + age, spd);
                end
            end
        end
    endtask

    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = pjsm_pkg::ACT_SAMPLE;
        m_tready   = 1'b0;
        beat_taken = 1'b0;
        src_calm   = 1'b0;
        snk_calm   = 1'b0;

        cfg_wd       = pjsm_pkg::WD_EN_RST;
        cfg_thr      = pjsm_pkg::THR_RST;
        cfg_timeout  = pjsm_pkg::TIMEOUT_RST;
        anchor_x     = '0;
        anchor_y     = '0;
        anchor_t     = '0;
        anchor_ok    = 1'b0;
        jump_pending = 1'b0;
        have_pose    = 1'b0;
        last_x       = '0;
        last_y       = '0;
        last_t       = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part under the reset settings.
        add_query(100, 500);                          // no pose yet
        add_query(100, 0);                            // standstill before any pose
        add_query(100, 10);                           // speed at the floor is standstill
        add_sample(0, 0, 1000, 1000);
        add_sample(100000, 0, 2000, 1000);            // plain jump
        add_query(2000, 1000);                        // jump reported and cleared
        add_query(602001, 1000);                      // stale
        add_query(502000, 1000);                      // age exactly at the timeout
        add_sample(-100000, 0, 1500, 1000);           // time going backwards
        add_query(1000, 1000);                        // query earlier than the pose
        add_sample(100000, 0, 1501, 1000);            // gap of exactly 1 us
        add_sample(-100000, 0, 1503, 11);             // slowest moving speed, jump
        add_sample(24'h800000, 24'h7FFFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF); // huge travel
        add_query(48'hFFFF_FFFF_FFFF, 0);             // standstill clears the latch
        add_sample(24'h7FFFFF, 24'h800000, 0, 16'hFFFF);
        add_sample(0, 0, 2, 16'hFFFF);
        add_query(2, 16'hFFFF);
        add_sample(500, 0, 1000, 100);                // distance equal to the threshold
        add_sample(1001, 0, 2000, 100);               // one above the threshold
        add_query(2000, 100);
        add_sample(2301, 0, 1002000, 1000);           // distance equal to 1.3 x travel
        add_sample(3602, 0, 2002000, 1000);           // one above 1.3 x travel
        add_query(2002000, 1000);
        wait_drain();

        apply_settings(1'b1, 16'd0, 32'd0);
        add_query(2002000, 1000);                     // zero timeout, zero age
        add_query(2002001, 1000);                     // zero timeout, any nonzero age is stale
        wait_drain();

        apply_settings(1'b0, 16'hFFFF, 32'hFFFF_FFFF);
        add_query(48'hFFFF_FFFF_FFFF, 1000);          // watchdog off, stale age ignored
        add_sample(-5000000, 5000000, 2002010, 1000); // watchdog off, no check
        wait_drain();

        cur_x = 0;
        cur_y = 0;
        cur_t = 48'd3000000;
        apply_settings(1'b1, 16'd500, 32'd500000);
        run_random(130);
        wait_drain();
        apply_settings(1'b1, 16'($urandom_range(0, 1000)), $urandom_range(1000, 300000));
        run_random(130);
        wait_drain();
        apply_settings(1'b1, 16'd0, 32'd0);
        run_random(70);
        wait_drain();
        apply_settings(1'b1, 16'hFFFF, 32'hFFFF_FFFF);
        run_random(70);
        wait_drain();
        apply_settings(1'b0, 16'($urandom), $urandom);
        run_random(70);
        wait_drain();
        apply_settings(1'b1, 16'($urandom), $urandom);
        run_random(130);
        wait_drain();

        // Room for a stray result to show up before the verdict.
        repeat (200) @(posedge clk);

        $display("Checked %0d results: %0d pose samples (%0d flagged as jumps), %0d queries",
                 n_checked, n_samples, n_jumps, n_queries);
        $display("Query verdicts: %0d healthy, %0d no pose, %0d jump, %0d stale",
                 reason_cnt[0], reason_cnt[1], reason_cnt[2], reason_cnt[3]);
        if (err_count == 0 && verdict_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
